// ===== hw/rtl/aftm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aftm_pkg
// shared widths, fit constants and pipeline depth of the filmic tone mapper
// ----------------------------------------------------------------------------
package aftm_pkg;

  localparam int CH_W    = 32;   // Q16.16 colour channel
  localparam int GAIN_W  = 27;   // Q11.16 exposure gain
  localparam int RES_W   = 17;   // Q1.16 result
  localparam int ALPHA_W = 32;

  // rational fit coefficients, unsigned Q0.32
  localparam logic [26:0] K_A = 27'd105564283;
  localparam logic [18:0] K_B = 19'd388853;
  localparam logic [31:0] K_C = 32'd4225083883;
  localparam logic [30:0] K_D = 31'd1859510386;
  localparam logic [29:0] K_E = 30'd1022550109;

  localparam int NUM_W  = 97;    // numerator and denominator, 2^-64 units
  localparam int REM_W  = 115;   // scaled dividend
  localparam int QBITS  = 17;    // quotient bits, one per divider stage
  localparam int PRE_STAGES = 5; // gain, square, numerator, denominator, dividend
  localparam int LAT    = PRE_STAGES + QBITS;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 27'd65536;

endpackage

// ===== hw/rtl/aces_filmic_tone_map_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aces_filmic_tone_map_top
// hdr to sdr filmic tone mapper; unless the receiver stalls, one rgba pixel per clock
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel beat of Q16.16 red, green, blue plus a 32-bit alpha,
//           taken when in_valid and in_ready are both high.
//   out_* : one Q1.16 result beat per pixel, alpha copied through, handed
//           over when out_valid and out_ready are both high.
//   cfg_* : exposure gain, Q11.16, written when cfg_valid is high (cfg_ready
//           is always high); write only while no pixel is in flight.
//   The pipeline has one gain stage, three stages of multiply and wide
//   add, one dividend stage and a 17-stage restoring divider, one
//   quotient bit per stage.
//   Throughput is one pixel per clock while out_ready stays high.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_ready drops, so no beat is lost or repeated.
//   Reset clears all valid bits and sets the gain to 1.0.
// ----------------------------------------------------------------------------
module aces_filmic_tone_map_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [aftm_pkg::CH_W-1:0]     in_red,
  input  logic [aftm_pkg::CH_W-1:0]     in_green,
  input  logic [aftm_pkg::CH_W-1:0]     in_blue,
  input  logic [aftm_pkg::ALPHA_W-1:0]  in_alpha,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aftm_pkg::RES_W-1:0]    out_red,
  output logic [aftm_pkg::RES_W-1:0]    out_green,
  output logic [aftm_pkg::RES_W-1:0]    out_blue,
  output logic [aftm_pkg::ALPHA_W-1:0]  out_alpha,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aftm_pkg::GAIN_W-1:0]   cfg_data
);
  import aftm_pkg::*;

  logic [GAIN_W-1:0]  gain_r;
  logic [LAT-1:0]     vld_r;
  logic [ALPHA_W-1:0] alpha_r [LAT];
  logic               en;

  // pipeline moves unless the last stage holds an untaken beat
  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];
  assign out_alpha = alpha_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_valid) begin
      gain_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r[0] <= in_alpha;
      for (int i = 1; i < LAT; i++) alpha_r[i] <= alpha_r[i-1];
    end
  end

  aftm_chan u_red (
    .clk   (clk),
    .en    (en),
    .in_x  (in_red),
    .gain  (gain_r),
    .out_q (out_red)
  );

  aftm_chan u_green (
    .clk   (clk),
    .en    (en),
    .in_x  (in_green),
    .gain  (gain_r),
    .out_q (out_green)
  );

  aftm_chan u_blue (
    .clk   (clk),
    .en    (en),
    .in_x  (in_blue),
    .gain  (gain_r),
    .out_q (out_blue)
  );

endmodule

// ===== hw/rtl/aftm_chan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aftm_chan
// one colour channel: exposure gain, rational fit, restoring divider pipeline
// ----------------------------------------------------------------------------
module aftm_chan (
  input  logic                       clk,
  input  logic                       en,
  input  logic [aftm_pkg::CH_W-1:0]  in_x,
  input  logic [aftm_pkg::GAIN_W-1:0] gain,
  output logic [aftm_pkg::RES_W-1:0] out_q
);
  import aftm_pkg::*;

  localparam logic [NUM_W-1:0] BT = NUM_W'(K_B) << 32;
  localparam logic [NUM_W-1:0] ET = NUM_W'(K_E) << 32;

  // stage 1: gain with saturation
  logic [CH_W+GAIN_W-1:0] prod;
  logic [CH_W-1:0]        x_r;
  assign prod = CH_W'(in_x) * (CH_W+GAIN_W)'(gain);

  always_ff @(posedge clk) begin
    if (en) begin
      if (|prod[CH_W+GAIN_W-1:CH_W+16]) x_r <= '1;
      else x_r <= prod[CH_W+15:16];
    end
  end

  // stage 2: square and linear terms
  logic [63:0] sq_r;
  logic [58:0] xa_r;
  logic [62:0] xd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= 64'(x_r) * 64'(x_r);
      xa_r <= 59'(x_r) * 59'(K_A);
      xd_r <= 63'(x_r) * 63'(K_D);
    end
  end

  // stage 3: numerator, zero test, split c*x^2
  logic [NUM_W-1:0] p;
  logic [NUM_W-1:0] n_r;
  logic             zero_r;
  logic [63:0]      csl_r, csh_r;
  logic [62:0]      xd3_r;
  assign p = (NUM_W'(sq_r) << 32) + (NUM_W'(xa_r) << 16);

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= p - BT;
      zero_r <= (p <= BT);
      csl_r  <= 64'(K_C) * 64'(sq_r[31:0]);
      csh_r  <= 64'(K_C) * 64'(sq_r[63:32]);
      xd3_r  <= xd_r;
    end
  end

  // stage 4: denominator
  logic [NUM_W-1:0] n4_r, d4_r;
  logic             zero4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d4_r    <= (NUM_W'(csh_r) << 32) + NUM_W'(csl_r) + (NUM_W'(xd3_r) << 16) + ET;
      n4_r    <= n_r;
      zero4_r <= zero_r;
    end
  end

  // stage 5: dividend with half-divisor rounding term
  logic [REM_W-1:0] num_r;
  logic [NUM_W-1:0] d5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero4_r) num_r <= '0;
      else num_r <= (REM_W'(n4_r) << QBITS) + REM_W'(d4_r);
      d5_r <= d4_r;
    end
  end

  // divider: one quotient bit per stage, msb first
  logic [REM_W-1:0] rem_r [QBITS];
  logic [NUM_W-1:0] dv_r  [QBITS];
  logic [RES_W-1:0] qb_r  [QBITS];

  genvar j;
  generate
    for (j = 0; j < QBITS; j++) begin : g_div
      logic [REM_W-1:0] rem_in;
      logic [NUM_W-1:0] dv_in;
      logic [RES_W-1:0] q_in;
      logic [REM_W-1:0] t;
      if (j == 0) begin : g_first
        assign rem_in = num_r;
        assign dv_in  = d5_r;
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem_r[j-1];
        assign dv_in  = dv_r[j-1];
        assign q_in   = qb_r[j-1];
      end
      assign t = REM_W'(dv_in) << (QBITS - j);

      always_ff @(posedge clk) begin
        if (en) begin
          dv_r[j] <= dv_in;
          if (t <= rem_in) begin
            rem_r[j] <= rem_in - t;
            qb_r[j]  <= q_in | (RES_W'(1) << (QBITS - 1 - j));
          end else begin
            rem_r[j] <= rem_in;
            qb_r[j]  <= q_in;
          end
        end
      end
    end
  endgenerate

  assign out_q = qb_r[QBITS-1];

endmodule

// ===== test/aftm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aftm_checker
// watches the pixel, result and gain channels of the filmic tone mapper,
// predicts every result beat from its own copy of the gain and compares
// ----------------------------------------------------------------------------
module aftm_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [aftm_pkg::CH_W-1:0]     in_red,
  input  logic [aftm_pkg::CH_W-1:0]     in_green,
  input  logic [aftm_pkg::CH_W-1:0]     in_blue,
  input  logic [aftm_pkg::ALPHA_W-1:0]  in_alpha,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [aftm_pkg::RES_W-1:0]    out_red,
  input  logic [aftm_pkg::RES_W-1:0]    out_green,
  input  logic [aftm_pkg::RES_W-1:0]    out_blue,
  input  logic [aftm_pkg::ALPHA_W-1:0]  out_alpha,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [aftm_pkg::GAIN_W-1:0]   cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import aftm_pkg::*;

  typedef struct packed {
    logic [RES_W-1:0]   red;
    logic [RES_W-1:0]   green;
    logic [RES_W-1:0]   blue;
    logic [ALPHA_W-1:0] alpha;
  } mapped_pixel_t;

  mapped_pixel_t    mapped_q[$];
  logic [GAIN_W-1:0] gain_model;

  // gain, saturate, then rational fit rounded to nearest in Q1.16
  function automatic logic [RES_W-1:0] filmic_curve(input logic [CH_W-1:0] ch,
                                                    input logic [GAIN_W-1:0] gain);
    logic [127:0] x, num, bterm, den, quo;
    x = (128'(ch) * 128'(gain)) >> 16;
    if (x > 128'hFFFF_FFFF) x = 128'hFFFF_FFFF;
    num   = ((x * x) << 32) + ((x * 128'(K_A)) << 16);
    bterm = 128'(K_B) << 32;
    if (num <= bterm) return '0;
    num = num - bterm;
    den = 128'(K_C) * x * x + ((128'(K_D) * x) << 16) + (128'(K_E) << 32);
    quo = ((num << 17) + den) / (den << 1);
    return quo[RES_W-1:0];
  endfunction

  assign pending = mapped_q.size();

  always @(posedge clk) begin
    mapped_pixel_t exp_px, got_px;
    if (!rst_n) begin
      gain_model = GAIN_RESET;
      mapped_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) gain_model = cfg_data;
      if (in_valid && in_ready) begin
        exp_px.red   = filmic_curve(in_red, gain_model);
        exp_px.green = filmic_curve(in_green, gain_model);
        exp_px.blue  = filmic_curve(in_blue, gain_model);
        exp_px.alpha = in_alpha;
        mapped_q.push_back(exp_px);
      end
      if (out_valid && out_ready) begin
        got_px = '{out_red, out_green, out_blue, out_alpha};
        if (mapped_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with none expected: r=%0d g=%0d b=%0d a=%h",
                     $realtime, out_red, out_green, out_blue, out_alpha);
        end else begin
          exp_px = mapped_q.pop_front();
          if (got_px !== exp_px) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp r=%0d g=%0d b=%0d a=%h got r=%0d g=%0d b=%0d a=%h",
                       $realtime, exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha,
                       out_red, out_green, out_blue, out_alpha);
          end
        end
      end
    end
  end

endmodule

// ===== test/tb_aces_filmic_tone_map_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aces_filmic_tone_map_top
// drives pixels and exposure gains into the tone mapper with random gaps and
// receiver stalls; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_aces_filmic_tone_map_top;
  import aftm_pkg::*;

  logic               clk, rst_n;
  logic               in_valid, in_ready;
  logic [CH_W-1:0]    in_red, in_green, in_blue;
  logic [ALPHA_W-1:0] in_alpha;
  logic               out_valid, out_ready;
  logic [RES_W-1:0]   out_red, out_green, out_blue;
  logic [ALPHA_W-1:0] out_alpha;
  logic               cfg_valid, cfg_ready;
  logic [GAIN_W-1:0]  cfg_data;
  int                 fail_count, pending;
  bit                 no_gaps;

  aces_filmic_tone_map_top uut (.*);

  aftm_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stall before each result beat
  initial begin
    int stall;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input logic [ALPHA_W-1:0] a);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    in_alpha <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  // gain writes only once the pipeline has drained
  task automatic write_gain(input logic [GAIN_W-1:0] gain);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
    cfg_valid <= 1;
    cfg_data  <= gain;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 400);           // around the zero knee
      3, 4, 5: return $urandom_range(0, 32'h0004_0000); // up to 4.0
      default: return $urandom_range(0, 32'h0000_FFFF); // below 1.0
    endcase
  endfunction

  initial begin
    logic [GAIN_W-1:0] gains [6];
    logic [CH_W-1:0]   corners [10];
    int n;
    gains   = '{27'd65536, 27'd64, 27'd67108864, 27'd0, 27'h7FF_FFFF, 27'd0};
    corners = '{32'd0, 32'd1, 32'd200, 32'd240, 32'd241, 32'd300, 32'h0001_0000,
                32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    no_gaps   = 0;
    in_valid  = 0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    in_alpha  = '0;
    cfg_valid = 0;
    cfg_data  = '0;
    rst_n     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed corners at reset gain
    foreach (corners[i])
      send_pixel(corners[i], corners[9 - i], corners[(i + 3) % 10],
                 (i % 2) ? 32'hFFFF_FFFF : 32'h0);
    send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hA5A5_5A5A);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 5) gains[5] = GAIN_W'($urandom_range(64, 67108864));
      if (ph < 6) write_gain(gains[ph]);
      else        write_gain(GAIN_W'($urandom_range(64, 67108864)));
      n = 180 + $urandom_range(0, 20);
      for (int k = 0; k < n; k++) begin
        if (k % 60 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        send_pixel(rand_channel(), rand_channel(), rand_channel(), $urandom());
      end
      no_gaps = 0;
    end
    in_valid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
